FILE: sv/piecewise_linear_lut_interp_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolation unit
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_LUT_INTERP_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_LUT_INTERP_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define PLLI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plli assertion failed");
// Next-cycle implication, disabled while reset is high.
`define PLLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plli assertion failed");
`else
`define PLLI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PLLI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/plli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolation package
// Widths, payload types, region codes and the default breakpoint table.
// ----------------------------------------------------------------------------
package plli_pkg;

   // Table size and field widths.
   localparam int POINTS = 5;
   localparam int PT_MAX = 8;
   localparam int PT_W   = 30;
   localparam int VOLT_W = 16;
   localparam int SOC_W  = 14;
   localparam int IDX_W  = $clog2(POINTS);

   typedef logic [VOLT_W-1:0] volt_type;
   typedef logic [SOC_W-1:0]  soc_type;
   typedef logic [PT_W-1:0]   point_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // Which case produced a result.
   typedef enum logic [1:0] {
      REGION_LOW  = 2'd0,
      REGION_MID  = 2'd1,
      REGION_HIGH = 2'd2
   } region_type;

   // Breakpoint values after reset: voltage in the upper field, charge below.
   localparam point_type PT_RESET [PT_MAX] = '{
      30'd49152000, 30'd52431800, 30'd53254000, 30'd54075200,
      30'd58992400, 30'd58992400, 30'd58992400, 30'd58992400
   };

   // Voltage field of a breakpoint.
   function automatic volt_type pt_volt(input point_type p);
      return p[PT_W-1 -: VOLT_W];
   endfunction

   // Charge field of a breakpoint.
   function automatic soc_type pt_soc(input point_type p);
      return p[SOC_W-1:0];
   endfunction

endpackage

FILE: sv/plli_req_if.sv
// ----------------------------------------------------------------------------
// Voltage sample channel
// Valid/ready channel that carries one voltage sample per beat.
// ----------------------------------------------------------------------------
interface plli_req_if;
   logic               valid;
   logic               ready;
   plli_pkg::volt_type voltage_mv;

   modport source (output valid, output voltage_mv, input ready);
   modport sink   (input valid, input voltage_mv, output ready);
endinterface

FILE: sv/plli_rsp_if.sv
// ----------------------------------------------------------------------------
// Charge result channel
// Valid/ready channel that carries one charge level and region per beat.
// ----------------------------------------------------------------------------
interface plli_rsp_if;
   logic              valid;
   logic              ready;
   plli_pkg::soc_type charge_level;
   logic [1:0]        region;

   modport source (output valid, output charge_level, output region, input ready);
   modport sink   (input valid, input charge_level, input region, output ready);
endinterface

FILE: sv/piecewise_linear_lut_interp_unit.sv
// ----------------------------------------------------------------------------
// Piecewise linear voltage to charge interpolation unit
// Segment search, product and a 7-stage pipelined restoring divider, with
// 12 register stages in all.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake               Payload
//   req_bus   in    valid / ready           voltage_mv[15:0]
//   rsp_bus   out   valid / ready           charge_level[13:0], region[1:0]
//   csr_*     in    csr_wr_en (no wait)     csr_index[2:0], csr_wdata[29:0]
//
// One beat is accepted per cycle unless a stall holds the input stage.
// The depth is set by the divider, which resolves two of 14 quotient bits per stage.
// Reset clears every stage valid bit and loads the default breakpoint table.
// A stall at the output holds only the stages that are full; empty stages
// further up keep filling, so bubbles are squeezed out.
//
`include "piecewise_linear_lut_interp_unit_macros.svh"

module piecewise_linear_lut_interp_unit (
   input  logic                clock,
   input  logic                reset,
   plli_req_if.sink            req_bus,
   plli_rsp_if.source          rsp_bus,
   input  logic                csr_wr_en,
   input  plli_pkg::idx_type   csr_index,
   input  plli_pkg::point_type csr_wdata
);

   // Stage map.
   localparam int QW       = plli_pkg::SOC_W;
   localparam int BPS      = 2;
   localparam int DIV_STG  = (QW + BPS - 1) / BPS;
   localparam int REM_W    = plli_pkg::VOLT_W + plli_pkg::SOC_W;
   localparam int ST_IN    = 0;
   localparam int ST_SRCH  = 1;
   localparam int ST_OPND  = 2;
   localparam int ST_PROD  = 3;
   localparam int ST_OUT   = ST_PROD + DIV_STG + 1;
   localparam int NSTG     = ST_OUT + 1;
   localparam int SEGS     = plli_pkg::POINTS - 1;
   localparam int LAST     = plli_pkg::POINTS - 1;

   // Breakpoint registers.
   plli_pkg::point_type pt_ff [plli_pkg::POINTS];

   // Pipeline control.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   // Input and search stages.
   plli_pkg::volt_type   v0_ff;
   plli_pkg::volt_type   v1_ff;
   plli_pkg::region_type region1_ff;
   plli_pkg::region_type region1_in;
   logic [SEGS-1:0]      segoh_ff;
   logic [SEGS-1:0]      segoh_in;
   logic [SEGS-1:0]      hits;

   // Operand stage.
   plli_pkg::volt_type   dv2_ff, dv2_in;
   plli_pkg::volt_type   den2_ff, den2_in;
   plli_pkg::soc_type    mag2_ff, mag2_in;
   logic                 neg2_ff, neg2_in;
   plli_pkg::soc_type    base2_ff, base2_in;
   logic                 use2_ff, use2_in;
   plli_pkg::region_type reg2_ff;

   // Product and divider stages; index 0 is the product stage.
   logic [REM_W-1:0]     rem_ff  [DIV_STG+1];
   logic [REM_W-1:0]     rem_in  [DIV_STG+1];
   logic [QW-1:0]        quo_ff  [DIV_STG+1];
   logic [QW-1:0]        quo_in  [DIV_STG+1];
   plli_pkg::volt_type   den_ff  [DIV_STG+1];
   plli_pkg::soc_type    base_ff [DIV_STG+1];
   logic                 neg_ff  [DIV_STG+1];
   logic                 use_ff  [DIV_STG+1];
   plli_pkg::region_type reg_ff  [DIV_STG+1];

   // Output register.
   plli_pkg::soc_type    charge_ff, charge_in;
   plli_pkg::region_type region_ff;

   // Configuration writes; indexes past the table are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < plli_pkg::POINTS; i++) begin
            pt_ff[i] <= plli_pkg::PT_RESET[i];
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < plli_pkg::POINTS; i++) begin
            if ({1'b0, csr_index} == (plli_pkg::IDX_W + 1)'(i)) begin
               pt_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      adv[ST_OUT] = !vld_ff[ST_OUT] || rsp_bus.ready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready = adv[ST_IN];

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[ST_IN]) begin
            vld_ff[ST_IN] <= req_bus.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Clamp decision and segment search; the lowest matching segment wins.
   always_comb begin
      if (v0_ff <= plli_pkg::pt_volt(pt_ff[0])) begin
         region1_in = plli_pkg::REGION_LOW;
      end else if (v0_ff >= plli_pkg::pt_volt(pt_ff[LAST])) begin
         region1_in = plli_pkg::REGION_HIGH;
      end else begin
         region1_in = plli_pkg::REGION_MID;
      end
      for (int i = 0; i < SEGS; i++) begin
         hits[i] = (v0_ff >= plli_pkg::pt_volt(pt_ff[i])) &&
                   (v0_ff <= plli_pkg::pt_volt(pt_ff[i+1]));
      end
      segoh_in = hits & (~hits + SEGS'(1));
   end

   // Segment operands, charge base and the divide enable.
   always_comb begin
      plli_pkg::volt_type vl;
      plli_pkg::volt_type vh;
      plli_pkg::soc_type  sl;
      plli_pkg::soc_type  sh;
      logic               found;
      vl    = '0;
      vh    = '0;
      sl    = '0;
      sh    = '0;
      found = |segoh_ff;
      for (int i = 0; i < SEGS; i++) begin
         if (segoh_ff[i]) begin
            vl = plli_pkg::pt_volt(pt_ff[i]);
            vh = plli_pkg::pt_volt(pt_ff[i+1]);
            sl = plli_pkg::pt_soc(pt_ff[i]);
            sh = plli_pkg::pt_soc(pt_ff[i+1]);
         end
      end
      dv2_in  = v1_ff - vl;
      den2_in = vh - vl;
      neg2_in = sh < sl;
      mag2_in = neg2_in ? (sl - sh) : (sh - sl);
      unique case (region1_ff)
         plli_pkg::REGION_LOW:  base2_in = plli_pkg::pt_soc(pt_ff[0]);
         plli_pkg::REGION_HIGH: base2_in = plli_pkg::pt_soc(pt_ff[LAST]);
         plli_pkg::REGION_MID:  base2_in = found ? sl : '0;
         default:               base2_in = '0;
      endcase
      use2_in = (region1_ff == plli_pkg::REGION_MID) && found && (den2_in != '0);
   end

   // Product, then two restoring division steps per stage.
   always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      logic [QW-1:0]    quo_t;
      int               j;
      rem_in[0] = REM_W'(dv2_ff) * REM_W'(mag2_ff);
      quo_in[0] = '0;
      for (int d = 1; d <= DIV_STG; d++) begin
         rem_t = rem_ff[d-1];
         quo_t = quo_ff[d-1];
         for (int b = 0; b < BPS; b++) begin
            j = QW - 1 - (d - 1) * BPS - b;
            if (j >= 0) begin
               trial = REM_W'(den_ff[d-1]) << j;
               if (rem_t >= trial) begin
                  rem_t = rem_t - trial;
                  quo_t = quo_t | (QW'(1) << j);
               end
            end
         end
         rem_in[d] = rem_t;
         quo_in[d] = quo_t;
      end
   end

   // Apply the sign of the slope; the sum wraps to the charge width.
   always_comb begin
      if (!use_ff[DIV_STG]) begin
         charge_in = base_ff[DIV_STG];
      end else if (neg_ff[DIV_STG]) begin
         charge_in = base_ff[DIV_STG] - quo_ff[DIV_STG];
      end else begin
         charge_in = base_ff[DIV_STG] + quo_ff[DIV_STG];
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         v0_ff <= req_bus.voltage_mv;
      end
      if (adv[ST_SRCH]) begin
         v1_ff      <= v0_ff;
         region1_ff <= region1_in;
         segoh_ff   <= segoh_in;
      end
      if (adv[ST_OPND]) begin
         dv2_ff   <= dv2_in;
         den2_ff  <= den2_in;
         mag2_ff  <= mag2_in;
         neg2_ff  <= neg2_in;
         base2_ff <= base2_in;
         use2_ff  <= use2_in;
         reg2_ff  <= region1_ff;
      end
      if (adv[ST_PROD]) begin
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         den_ff[0]  <= den2_ff;
         base_ff[0] <= base2_ff;
         neg_ff[0]  <= neg2_ff;
         use_ff[0]  <= use2_ff;
         reg_ff[0]  <= reg2_ff;
      end
      for (int d = 1; d <= DIV_STG; d++) begin
         if (adv[ST_PROD+d]) begin
            rem_ff[d]  <= rem_in[d];
            quo_ff[d]  <= quo_in[d];
            den_ff[d]  <= den_ff[d-1];
            base_ff[d] <= base_ff[d-1];
            neg_ff[d]  <= neg_ff[d-1];
            use_ff[d]  <= use_ff[d-1];
            reg_ff[d]  <= reg_ff[d-1];
         end
      end
      if (adv[ST_OUT]) begin
         charge_ff <= charge_in;
         region_ff <= reg_ff[DIV_STG];
      end
   end

   // Result channel.
   assign rsp_bus.valid        = vld_ff[ST_OUT];
   assign rsp_bus.charge_level = charge_ff;
   assign rsp_bus.region       = region_ff;

   // The dividend must leave the quotient inside the charge width.
   `PLLI_ASSERT_IMPL(a_div_entry_bound, clock, reset, vld_ff[ST_PROD] && use_ff[0], rem_ff[0] < (REM_W'(den_ff[0]) << QW))
   // After the last step the remainder is below the divisor.
   `PLLI_ASSERT_IMPL(a_div_final_rem, clock, reset, vld_ff[ST_OUT-1] && use_ff[DIV_STG], rem_ff[DIV_STG] < REM_W'(den_ff[DIV_STG]))
   // Clamped results never take the divider path.
   `PLLI_ASSERT_IMPL(a_clamp_no_div, clock, reset, vld_ff[ST_PROD] && (reg_ff[0] != plli_pkg::REGION_MID), !use_ff[0])
   // A held product stage keeps its beat and its dividend.
   `PLLI_ASSERT_NEXT(a_prod_hold, clock, reset, vld_ff[ST_PROD] && !adv[ST_PROD], vld_ff[ST_PROD] && $stable(rem_ff[0]))

endmodule
